// ===== sv/csl_pkg.sv =====
`timescale 1ns / 1ps

package csl_pkg;

   // Identifier buffer size (default for the top level parameter)
   localparam int CSL_MAX_IDENT = 32;

   localparam int KIND_W   = 5;
   localparam int VALUE_W  = 31;
   localparam int CHAR_W   = 8;
   localparam int LINE_W   = 16;
   localparam int RSP_DATA_W = 56;
   localparam int KW_COUNT = 7;

   localparam logic [VALUE_W-1:0] NUM_MAX  = '1;
   localparam logic [LINE_W-1:0]  LINE_MAX = '1;

   // Token kinds
   localparam logic [KIND_W-1:0] TK_INT_LIT = 5'd0;
   localparam logic [KIND_W-1:0] TK_IDENT   = 5'd1;
   localparam logic [KIND_W-1:0] TK_BREAK   = 5'd2;
   localparam logic [KIND_W-1:0] TK_LPAREN  = 5'd9;
   localparam logic [KIND_W-1:0] TK_RPAREN  = 5'd10;
   localparam logic [KIND_W-1:0] TK_LBRACE  = 5'd11;
   localparam logic [KIND_W-1:0] TK_RBRACE  = 5'd12;
   localparam logic [KIND_W-1:0] TK_STAR    = 5'd13;
   localparam logic [KIND_W-1:0] TK_PLUS    = 5'd14;
   localparam logic [KIND_W-1:0] TK_MINUS   = 5'd15;
   localparam logic [KIND_W-1:0] TK_SLASH   = 5'd16;
   localparam logic [KIND_W-1:0] TK_PERCENT = 5'd17;
   localparam logic [KIND_W-1:0] TK_BANG    = 5'd18;
   localparam logic [KIND_W-1:0] TK_LT      = 5'd19;
   localparam logic [KIND_W-1:0] TK_GT      = 5'd20;
   localparam logic [KIND_W-1:0] TK_LE      = 5'd21;
   localparam logic [KIND_W-1:0] TK_GE      = 5'd22;
   localparam logic [KIND_W-1:0] TK_EQ      = 5'd23;
   localparam logic [KIND_W-1:0] TK_NE      = 5'd24;
   localparam logic [KIND_W-1:0] TK_SEMI    = 5'd25;
   localparam logic [KIND_W-1:0] TK_ASSIGN  = 5'd26;
   localparam logic [KIND_W-1:0] TK_COMMA   = 5'd27;
   localparam logic [KIND_W-1:0] TK_END     = 5'd28;
   localparam logic [KIND_W-1:0] TK_ERROR   = 5'd29;

   // Byte classes found by the front end
   typedef enum logic [3:0] {
      CC_SPACE,
      CC_NEWLINE,
      CC_DIGIT,
      CC_LETTER,
      CC_LT,
      CC_GT,
      CC_EQUAL,
      CC_BANG,
      CC_SYMBOL,
      CC_UNKNOWN,
      CC_END
   } char_class_type;

   // One classified source byte, queued between front and back
   typedef struct packed {
      char_class_type      cls;
      logic [KIND_W-1:0]   sym_kind;
      logic [CHAR_W-1:0]   char_code;
   } csl_item_type;

   // Pending-token mode of the lexer
   typedef enum logic [2:0] {
      LM_IDLE,
      LM_NUM,
      LM_IDENT,
      LM_LT,
      LM_GT,
      LM_ASSIGN,
      LM_BANG,
      LM_HALT
   } lex_mode_type;

   // Back end sequencer
   typedef enum logic [1:0] {
      BK_SCAN,
      BK_ID_RUN,
      BK_PEND
   } back_state_type;

   // Keyword length, keyword k gives token kind TK_BREAK + k
   function automatic logic [5:0] kw_len(input logic [2:0] k);
      logic [5:0] n;
      case (k)
         3'd0:    n = 6'd5;
         3'd1:    n = 6'd8;
         3'd2:    n = 6'd4;
         3'd3:    n = 6'd2;
         3'd4:    n = 6'd3;
         3'd5:    n = 6'd6;
         3'd6:    n = 6'd5;
         default: n = 6'd0;
      endcase
      return n;
   endfunction

   // Character of keyword k at position pos, zero past its end
   function automatic logic [CHAR_W-1:0] kw_char(input logic [2:0] k,
                                                 input logic [5:0] pos);
      logic [63:0] word;
      logic [5:0]  n;
      logic [2:0]  sel;
      case (k)
         3'd0:    word = 64'("break");
         3'd1:    word = 64'("continue");
         3'd2:    word = 64'("else");
         3'd3:    word = 64'("if");
         3'd4:    word = 64'("int");
         3'd5:    word = 64'("return");
         3'd6:    word = 64'("while");
         default: word = '0;
      endcase
      n   = kw_len(k);
      // the first character sits in the highest used byte
      sel = 3'(n - 6'd1 - pos);
      if (pos < n) begin
         return word[{sel, 3'b000} +: 8];
      end
      return '0;
   endfunction

endpackage

// ===== sv/csl_ram.sv =====
`timescale 1ns / 1ps

module csl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/csl_front.sv =====
`timescale 1ns / 1ps

module csl_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] char_code
   input  logic                       req_tuser,   // [0] end_of_input
   output logic                       item_valid,
   output csl_pkg::csl_item_type      item,
   input  logic                       item_pop
);

   import csl_pkg::*;

   csl_item_type q_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   csl_item_type cls_item;
   logic         push;

   // Classify the incoming byte
   always_comb begin
      cls_item.char_code = req_tdata;
      cls_item.sym_kind  = '0;
      cls_item.cls       = CC_UNKNOWN;
      if (req_tuser) begin
         cls_item.cls = CC_END;
      end else if (req_tdata >= "0" && req_tdata <= "9") begin
         cls_item.cls = CC_DIGIT;
      end else if ((req_tdata >= "a" && req_tdata <= "z") ||
                   (req_tdata >= "A" && req_tdata <= "Z") || req_tdata == "_") begin
         cls_item.cls = CC_LETTER;
      end else begin
         case (req_tdata)
            8'd32, 8'd9: cls_item.cls = CC_SPACE;
            8'd10:       cls_item.cls = CC_NEWLINE;
            "<":         cls_item.cls = CC_LT;
            ">":         cls_item.cls = CC_GT;
            "=":         cls_item.cls = CC_EQUAL;
            "!":         cls_item.cls = CC_BANG;
            "(": begin cls_item.cls = CC_SYMBOL; cls_item.sym_kind = TK_LPAREN;  end
            ")": begin cls_item.cls = CC_SYMBOL; cls_item.sym_kind = TK_RPAREN;  end
            "{": begin cls_item.cls = CC_SYMBOL; cls_item.sym_kind = TK_LBRACE;  end
            "}": begin cls_item.cls = CC_SYMBOL; cls_item.sym_kind = TK_RBRACE;  end
            "*": begin cls_item.cls = CC_SYMBOL; cls_item.sym_kind = TK_STAR;    end
            "+": begin cls_item.cls = CC_SYMBOL; cls_item.sym_kind = TK_PLUS;    end
            "-": begin cls_item.cls = CC_SYMBOL; cls_item.sym_kind = TK_MINUS;   end
            "/": begin cls_item.cls = CC_SYMBOL; cls_item.sym_kind = TK_SLASH;   end
            "%": begin cls_item.cls = CC_SYMBOL; cls_item.sym_kind = TK_PERCENT; end
            ";": begin cls_item.cls = CC_SYMBOL; cls_item.sym_kind = TK_SEMI;    end
            ",": begin cls_item.cls = CC_SYMBOL; cls_item.sym_kind = TK_COMMA;   end
            default: cls_item.cls = CC_UNKNOWN;
         endcase
      end
   end

   // Two-entry queue toward the back end
   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls_item;
      end
   end

endmodule

// ===== sv/csl_back.sv =====
`timescale 1ns / 1ps

module csl_back #(
   parameter int MAX_IDENT = csl_pkg::CSL_MAX_IDENT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_valid,
   input  csl_pkg::csl_item_type               item,
   output logic                                item_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [csl_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [csl_pkg::KIND_W-1:0]          rsp_tuser,
   output logic                                rsp_tlast
);

   import csl_pkg::*;

   localparam int AW = $clog2(MAX_IDENT);
   localparam int LW = $clog2(MAX_IDENT + 1);
   localparam logic [LW-1:0] LEN_MAX = LW'(MAX_IDENT);

   back_state_type     state_ff, state_in;
   lex_mode_type       mode_ff, mode_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [LW-1:0]      len_ff, len_in;
   logic               ovf_ff, ovf_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   logic [KW_COUNT-1:0] kwm_ff, kwm_in;

   logic [LINE_W-1:0]  ev_line_ff, ev_line_in;
   logic [LW-1:0]      run_len_ff, run_len_in;
   logic               run_ovf_ff, run_ovf_in;
   logic [LW-1:0]      idx_ff, idx_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [KIND_W-1:0]  pend_kind_ff, pend_kind_in;

   logic               o_valid_ff, o_valid_in;
   logic [KIND_W-1:0]  o_kind_ff, o_kind_in;
   logic [VALUE_W-1:0] o_value_ff, o_value_in;
   logic [CHAR_W-1:0]  o_char_ff, o_char_in;
   logic [LINE_W-1:0]  o_line_ff, o_line_in;
   logic               o_ovf_ff, o_ovf_in;
   logic               o_last_ff, o_last_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [CHAR_W-1:0]  wr_data;
   logic [AW-1:0]      rd_addr;
   logic [CHAR_W-1:0]  rd_data;

   // Identifier characters
   csl_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (MAX_IDENT)
   ) u_ident_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Lexer step, token emission and identifier run sequencing
   always_comb begin
      logic              slot_free;
      logic              flush;
      logic              f_tok_v;
      logic [KIND_W-1:0] f_kind;
      logic [VALUE_W-1:0] f_val;
      logic              f_ovf;
      logic              f_run;
      logic              s_tok_v;
      logic [KIND_W-1:0] s_kind;
      logic              kw_hit;
      logic [KIND_W-1:0] kw_kind;
      logic [3:0]        digit;
      logic [34:0]       prod;
      logic              run_last;

      state_in      = state_ff;
      mode_in       = mode_ff;
      acc_in        = acc_ff;
      len_in        = len_ff;
      ovf_in        = ovf_ff;
      line_in       = line_ff;
      kwm_in        = kwm_ff;
      ev_line_in    = ev_line_ff;
      run_len_in    = run_len_ff;
      run_ovf_in    = run_ovf_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;

      slot_free  = !o_valid_ff || rsp_tready;
      o_valid_in = o_valid_ff && !rsp_tready;
      o_kind_in  = o_kind_ff;
      o_value_in = o_value_ff;
      o_char_in  = o_char_ff;
      o_line_in  = o_line_ff;
      o_ovf_in   = o_ovf_ff;
      o_last_in  = o_last_ff;

      item_pop = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = len_ff[AW-1:0];
      wr_data  = item.char_code;

      flush   = 1'b0;
      f_tok_v = 1'b0;
      f_kind  = TK_INT_LIT;
      f_val   = '0;
      f_ovf   = 1'b0;
      f_run   = 1'b0;
      s_tok_v = 1'b0;
      s_kind  = TK_END;

      digit = 4'(item.char_code - 8'd48);
      prod  = 35'({acc_ff, 3'b000}) + 35'({acc_ff, 1'b0}) + 35'(digit);
      run_last = (LW'(idx_ff + 1'b1) == run_len_ff);

      // keyword whose characters all matched and whose length agrees
      kw_hit  = 1'b0;
      kw_kind = TK_BREAK;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (kwm_ff[k] && (6'(len_ff) == kw_len(3'(k)))) begin
            kw_hit  = 1'b1;
            kw_kind = TK_BREAK + KIND_W'(k);
         end
      end

      unique case (state_ff)
         BK_SCAN: begin
            if (item_valid && slot_free) begin
               item_pop   = 1'b1;
               ev_line_in = line_ff;
               if (mode_ff != LM_HALT) begin
                  // continue the pending token or decide to end it
                  if (item.cls == CC_END) begin
                     flush   = 1'b1;
                     s_tok_v = 1'b1;
                     s_kind  = TK_END;
                  end else begin
                     unique case (mode_ff)
                        LM_NUM: begin
                           if (item.cls == CC_DIGIT) begin
                              if (prod > 35'(NUM_MAX)) begin
                                 acc_in = NUM_MAX;
                                 ovf_in = 1'b1;
                              end else begin
                                 acc_in = prod[VALUE_W-1:0];
                              end
                           end else begin
                              flush = 1'b1;
                           end
                        end
                        LM_IDENT: begin
                           if (item.cls == CC_LETTER || item.cls == CC_DIGIT) begin
                              if (len_ff < LEN_MAX) begin
                                 wr_en  = 1'b1;
                                 len_in = len_ff + 1'b1;
                                 for (int k = 0; k < KW_COUNT; k++) begin
                                    kwm_in[k] = kwm_ff[k] &&
                                       (kw_char(3'(k), 6'(len_ff)) == item.char_code);
                                 end
                              end else begin
                                 ovf_in = 1'b1;
                              end
                           end else begin
                              flush = 1'b1;
                           end
                        end
                        LM_LT, LM_GT, LM_ASSIGN, LM_BANG: begin
                           if (item.cls == CC_EQUAL) begin
                              f_tok_v = 1'b1;
                              mode_in = LM_IDLE;
                              unique case (mode_ff)
                                 LM_LT:   f_kind = TK_LE;
                                 LM_GT:   f_kind = TK_GE;
                                 LM_ASSIGN: f_kind = TK_EQ;
                                 default: f_kind = TK_NE;
                              endcase
                           end else begin
                              flush = 1'b1;
                           end
                        end
                        default: flush = 1'b1;
                     endcase
                  end

                  if (flush) begin
                     // end the pending token
                     unique case (mode_ff)
                        LM_NUM: begin
                           f_tok_v = 1'b1;
                           f_kind  = TK_INT_LIT;
                           f_val   = acc_ff;
                           f_ovf   = ovf_ff;
                        end
                        LM_IDENT: begin
                           if (!ovf_ff && kw_hit) begin
                              f_tok_v = 1'b1;
                              f_kind  = kw_kind;
                           end else begin
                              f_run = 1'b1;
                           end
                        end
                        LM_LT:     begin f_tok_v = 1'b1; f_kind = TK_LT;     end
                        LM_GT:     begin f_tok_v = 1'b1; f_kind = TK_GT;     end
                        LM_ASSIGN: begin f_tok_v = 1'b1; f_kind = TK_ASSIGN; end
                        LM_BANG:   begin f_tok_v = 1'b1; f_kind = TK_BANG;   end
                        default: ;
                     endcase
                     mode_in = LM_IDLE;

                     // handle the byte afresh, or return to reset state at end
                     if (item.cls == CC_END) begin
                        acc_in  = '0;
                        len_in  = '0;
                        ovf_in  = 1'b0;
                        line_in = LINE_W'(1);
                        kwm_in  = '0;
                     end else begin
                        unique case (item.cls)
                           CC_NEWLINE: begin
                              if (line_ff != LINE_MAX) begin
                                 line_in = line_ff + 1'b1;
                              end
                           end
                           CC_DIGIT: begin
                              mode_in = LM_NUM;
                              acc_in  = VALUE_W'(digit);
                              ovf_in  = 1'b0;
                           end
                           CC_LETTER: begin
                              mode_in = LM_IDENT;
                              wr_en   = 1'b1;
                              wr_addr = '0;
                              len_in  = LW'(1);
                              ovf_in  = 1'b0;
                              for (int k = 0; k < KW_COUNT; k++) begin
                                 kwm_in[k] = (kw_char(3'(k), 6'd0) == item.char_code);
                              end
                           end
                           CC_LT:    mode_in = LM_LT;
                           CC_GT:    mode_in = LM_GT;
                           CC_EQUAL: mode_in = LM_ASSIGN;
                           CC_BANG:  mode_in = LM_BANG;
                           CC_SYMBOL: begin
                              s_tok_v = 1'b1;
                              s_kind  = item.sym_kind;
                           end
                           CC_UNKNOWN: begin
                              s_tok_v = 1'b1;
                              s_kind  = TK_ERROR;
                              mode_in = LM_HALT;
                           end
                           default: ;
                        endcase
                     end
                  end
               end

               // dispatch: first result now, the rest from the run or pending slot
               pend_kind_in = s_kind;
               if (f_tok_v) begin
                  o_valid_in    = 1'b1;
                  o_kind_in     = f_kind;
                  o_value_in    = f_val;
                  o_char_in     = '0;
                  o_line_in     = line_ff;
                  o_ovf_in      = f_ovf;
                  o_last_in     = 1'b1;
                  pend_valid_in = s_tok_v;
                  if (s_tok_v) begin
                     state_in = BK_PEND;
                  end
               end else if (f_run) begin
                  state_in      = BK_ID_RUN;
                  idx_in        = '0;
                  run_len_in    = len_ff;
                  run_ovf_in    = ovf_ff;
                  pend_valid_in = s_tok_v;
               end else if (s_tok_v) begin
                  o_valid_in = 1'b1;
                  o_kind_in  = s_kind;
                  o_value_in = '0;
                  o_char_in  = '0;
                  o_line_in  = line_ff;
                  o_ovf_in   = 1'b0;
                  o_last_in  = 1'b1;
               end
            end
         end
         BK_ID_RUN: begin
            // stream identifier characters out of the buffer
            if (slot_free) begin
               o_valid_in = 1'b1;
               o_kind_in  = TK_IDENT;
               o_value_in = '0;
               o_char_in  = rd_data;
               o_line_in  = ev_line_ff;
               o_ovf_in   = run_ovf_ff;
               o_last_in  = run_last;
               idx_in     = LW'(idx_ff + 1'b1);
               if (run_last) begin
                  state_in = pend_valid_ff ? BK_PEND : BK_SCAN;
               end
            end
         end
         BK_PEND: begin
            // token that follows the flushed one in the same step
            if (slot_free) begin
               o_valid_in    = 1'b1;
               o_kind_in     = pend_kind_ff;
               o_value_in    = '0;
               o_char_in     = '0;
               o_line_in     = ev_line_ff;
               o_ovf_in      = 1'b0;
               o_last_in     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = BK_SCAN;
            end
         end
         default: state_in = BK_SCAN;
      endcase

      // read at idx_in so the registered data matches idx_ff
      rd_addr = idx_in[AW-1:0];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_SCAN;
         mode_ff       <= LM_IDLE;
         acc_ff        <= '0;
         len_ff        <= '0;
         ovf_ff        <= 1'b0;
         line_ff       <= LINE_W'(1);
         kwm_ff        <= '0;
         pend_valid_ff <= 1'b0;
         o_valid_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         acc_ff        <= acc_in;
         len_ff        <= len_in;
         ovf_ff        <= ovf_in;
         line_ff       <= line_in;
         kwm_ff        <= kwm_in;
         pend_valid_ff <= pend_valid_in;
         o_valid_ff    <= o_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      ev_line_ff   <= ev_line_in;
      run_len_ff   <= run_len_in;
      run_ovf_ff   <= run_ovf_in;
      idx_ff       <= idx_in;
      pend_kind_ff <= pend_kind_in;
      o_kind_ff    <= o_kind_in;
      o_value_ff   <= o_value_in;
      o_char_ff    <= o_char_in;
      o_line_ff    <= o_line_in;
      o_ovf_ff     <= o_ovf_in;
      o_last_ff    <= o_last_in;
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = {o_ovf_ff, o_line_ff, o_char_ff, o_value_ff};
   assign rsp_tuser  = o_kind_ff;
   assign rsp_tlast  = o_last_ff;

endmodule

// ===== sv/c_subset_lexer.sv =====
`timescale 1ns / 1ps

// Lexer for a small C subset. Each request transaction carries one source byte, or an end
// mark in tuser that flushes the pending token, emits the end token and returns the block
// to line 1. Each response transaction is one token; a plain identifier comes out as a run
// of one transaction per character with tlast on the final one. A front end classifies
// bytes into a two-entry queue, and the back end takes one queued byte per cycle whenever
// its output register is free and it is not sending a second result or an identifier run.
// A step that yields two results sends the second from the pending slot, and a plain
// identifier is streamed from the identifier buffer RAM. A request passes through the
// queue and the output register before its first response; a step that starts an
// identifier run also passes the registered RAM read. An unknown byte yields an error
// token, after which every transaction is consumed without output until reset.
module c_subset_lexer #(
   parameter int MAX_IDENT = csl_pkg::CSL_MAX_IDENT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] char_code
   input  logic                            req_tuser,   // [0] end_of_input
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [30:0] int_value, [38:31] id_char, [54:39] line_number, [55] overflow
   output logic [csl_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [csl_pkg::KIND_W-1:0]      rsp_tuser,   // [4:0] token_kind
   output logic                            rsp_tlast
);

   import csl_pkg::*;

   logic         item_valid;
   csl_item_type item;
   logic         item_pop;

   csl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   csl_back #(
      .MAX_IDENT (MAX_IDENT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== verif/c_subset_lexer_tb.sv =====
`timescale 1ns / 1ps

module c_subset_lexer_tb;
   import csl_pkg::*;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_ALL_ONE = 8'hFF;
   localparam int         SETTLE_CYCLES = 8;

   // One expected response transaction
   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      logic [CHAR_W-1:0]  ch;
      logic [LINE_W-1:0]  line;
      logic               ovf;
      logic               last;
   } token_rec_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = 8'd0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [KIND_W-1:0]      rsp_tuser;
   logic                   rsp_tlast;

   // Lexer state mirrored by the predictor
   lex_mode_type           lex_mode;
   logic [VALUE_W-1:0]     num_acc;
   logic [7:0]             id_buf [CSL_MAX_IDENT];
   int                     id_len;
   logic [LINE_W-1:0]      line_cnt;
   logic                   ovf_seen;

   token_rec_type          tokens_due[$];
   int                     token_errors = 0;
   int                     bytes_sent   = 0;
   int                     src_idle_pct = 0;
   int                     snk_idle_pct = 0;
   int                     hold_off     = 0;

   string kw_words [7] = '{"break", "continue", "else", "if", "int", "return", "while"};
   string op_texts [19] = '{"(", ")", "{", "}", "*", "+", "-", "/", "%", ";", ",",
                            "<", ">", "=", "!", "<=", ">=", "==", "!="};

   c_subset_lexer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Character classes
   // ------------------------------------------------------------------
   function automatic bit is_digit_ch(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_letter_ch(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   // Kind of a single-character symbol, TK_ERROR if c is not one
   function automatic logic [KIND_W-1:0] symbol_kind(logic [7:0] c);
      case (c)
         "(":     return TK_LPAREN;
         ")":     return TK_RPAREN;
         "{":     return TK_LBRACE;
         "}":     return TK_RBRACE;
         "*":     return TK_STAR;
         "+":     return TK_PLUS;
         "-":     return TK_MINUS;
         "/":     return TK_SLASH;
         "%":     return TK_PERCENT;
         ";":     return TK_SEMI;
         ",":     return TK_COMMA;
         default: return TK_ERROR;
      endcase
   endfunction

   function automatic bit char_known(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE || is_digit_ch(c) ||
             is_letter_ch(c) || c == "<" || c == ">" || c == "=" || c == "!" ||
             symbol_kind(c) != TK_ERROR;
   endfunction

   // ------------------------------------------------------------------
   // Token predictor
   // ------------------------------------------------------------------
   task automatic clear_lexer();
      lex_mode = LM_IDLE;
      num_acc  = '0;
      id_len   = 0;
      line_cnt = 16'd1;
      ovf_seen = 1'b0;
   endtask

   task automatic push_token(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                             input logic [7:0] ch, input logic ovf, input logic last);
      token_rec_type t;
      t.kind  = kind;
      t.value = value;
      t.ch    = ch;
      t.line  = line_cnt;
      t.ovf   = ovf;
      t.last  = last;
      tokens_due.push_back(t);
   endtask

   // Emit whatever token is pending and go idle
   task automatic flush_pending();
      int k;
      int i;
      int hit;
      hit = -1;
      case (lex_mode)
         LM_NUM: push_token(TK_INT_LIT, num_acc, 8'd0, ovf_seen, 1'b1);
         LM_IDENT: begin
            if (!ovf_seen) begin
               for (k = 0; k < 7; k++) begin
                  if (kw_words[k].len() == id_len && hit < 0) begin
                     hit = k;
                     for (i = 0; i < id_len; i++) begin
                        if (kw_words[k][i] != id_buf[i]) hit = -1;
                     end
                  end
               end
            end
            if (hit >= 0) begin
               push_token(TK_BREAK + KIND_W'(hit), '0, 8'd0, 1'b0, 1'b1);
            end else begin
               for (i = 0; i < id_len; i++) begin
                  push_token(TK_IDENT, '0, id_buf[i], ovf_seen, i + 1 == id_len);
               end
            end
         end
         LM_LT:     push_token(TK_LT, '0, 8'd0, 1'b0, 1'b1);
         LM_GT:     push_token(TK_GT, '0, 8'd0, 1'b0, 1'b1);
         LM_ASSIGN: push_token(TK_ASSIGN, '0, 8'd0, 1'b0, 1'b1);
         LM_BANG:   push_token(TK_BANG, '0, 8'd0, 1'b0, 1'b1);
         default: ;
      endcase
      lex_mode = LM_IDLE;
   endtask

   // Handle a byte from the idle mode
   task automatic begin_token(input logic [7:0] c);
      if (c == CH_SPACE || c == CH_TAB) return;
      if (c == CH_NEWLINE) begin
         if (line_cnt < LINE_MAX) line_cnt++;
         return;
      end
      if (is_digit_ch(c)) begin
         lex_mode = LM_NUM;
         num_acc  = VALUE_W'(c - "0");
         ovf_seen = 1'b0;
      end else if (is_letter_ch(c)) begin
         lex_mode  = LM_IDENT;
         id_buf[0] = c;
         id_len    = 1;
         ovf_seen  = 1'b0;
      end else if (c == "<") begin
         lex_mode = LM_LT;
      end else if (c == ">") begin
         lex_mode = LM_GT;
      end else if (c == "=") begin
         lex_mode = LM_ASSIGN;
      end else if (c == "!") begin
         lex_mode = LM_BANG;
      end else begin
         push_token(symbol_kind(c), '0, 8'd0, 1'b0, 1'b1);
         if (symbol_kind(c) == TK_ERROR) lex_mode = LM_HALT;
      end
   endtask

   // Advance the predictor by one accepted request transaction
   task automatic tokenize_byte(input logic [7:0] c, input logic eoi);
      logic [63:0] wide;
      if (lex_mode == LM_HALT) return;
      if (eoi) begin
         flush_pending();
         push_token(TK_END, '0, 8'd0, 1'b0, 1'b1);
         clear_lexer();
         return;
      end
      case (lex_mode)
         LM_NUM: begin
            if (is_digit_ch(c)) begin
               wide = 64'(num_acc) * 64'd10 + 64'(c - "0");
               if (wide > 64'(NUM_MAX)) begin
                  wide     = 64'(NUM_MAX);
                  ovf_seen = 1'b1;
               end
               num_acc = wide[VALUE_W-1:0];
               return;
            end
         end
         LM_IDENT: begin
            if (is_letter_ch(c) || is_digit_ch(c)) begin
               if (id_len < CSL_MAX_IDENT) begin
                  id_buf[id_len] = c;
                  id_len++;
               end else begin
                  ovf_seen = 1'b1;
               end
               return;
            end
         end
         LM_LT, LM_GT, LM_ASSIGN, LM_BANG: begin
            if (c == "=") begin
               case (lex_mode)
                  LM_LT:   push_token(TK_LE, '0, 8'd0, 1'b0, 1'b1);
                  LM_GT:   push_token(TK_GE, '0, 8'd0, 1'b0, 1'b1);
                  LM_BANG: push_token(TK_NE, '0, 8'd0, 1'b0, 1'b1);
                  default: push_token(TK_EQ, '0, 8'd0, 1'b0, 1'b1);
               endcase
               lex_mode = LM_IDLE;
               return;
            end
         end
         default: ;
      endcase
      flush_pending();
      begin_token(c);
   endtask

   // ------------------------------------------------------------------
   // Response side: ready pattern and checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("[%0t] token mismatch: %s", $realtime, msg);
      token_errors++;
   endtask

   // Drop ready at random, or for a whole hold-off stretch
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
   end

   // Compare each response transaction with the oldest expected token
   always @(posedge clock) begin : check_tokens
      token_rec_type want;
      string         diffs;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tokens_due.size() == 0) begin
            report_mismatch($sformatf("unexpected kind %0d line %0d",
                                      rsp_tuser, rsp_tdata[54:39]));
         end else begin
            want  = tokens_due.pop_front();
            diffs = "";
            if (rsp_tuser !== want.kind)
               diffs = {diffs, $sformatf(" kind %0d/%0d", rsp_tuser, want.kind)};
            if (rsp_tdata[30:0] !== want.value)
               diffs = {diffs, $sformatf(" value %0d/%0d", rsp_tdata[30:0], want.value)};
            if (rsp_tdata[38:31] !== want.ch)
               diffs = {diffs, $sformatf(" char %0h/%0h", rsp_tdata[38:31], want.ch)};
            if (rsp_tdata[54:39] !== want.line)
               diffs = {diffs, $sformatf(" line %0d/%0d", rsp_tdata[54:39], want.line)};
            if (rsp_tdata[55] !== want.ovf)
               diffs = {diffs, $sformatf(" overflow %b/%b", rsp_tdata[55], want.ovf)};
            if (rsp_tlast !== want.last)
               diffs = {diffs, $sformatf(" last %b/%b", rsp_tlast, want.last)};
            if (diffs != "") report_mismatch({"got/expected:", diffs});
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] c, input logic eoi);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= eoi;
      do @(posedge clock); while (!req_tready);
      tokenize_byte(c, eoi);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   // End mark carries a random byte that must be ignored
   task automatic send_end_mark();
      send_byte(8'($urandom_range(255)), 1'b1);
   endtask

   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return "_";
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'("0" + $urandom_range(9));
   endfunction

   function automatic logic [7:0] rand_blank();
      case ($urandom_range(2))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         default: return CH_NEWLINE;
      endcase
   endfunction

   task automatic send_ident(input int n);
      int i;
      send_byte(rand_letter(), 1'b0);
      for (i = 1; i < n; i++) begin
         send_byte(($urandom_range(3) == 0) ? rand_digit() : rand_letter(), 1'b0);
      end
   endtask

   // Stop offering, wait for every expected token, then let the pipe settle
   task automatic wait_for_tokens();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random token-shaped fragment, usually followed by a blank
   task automatic send_random_fragment();
      int pick;
      int n;
      int i;
      pick = $urandom_range(99);
      if (pick < 25) begin
         n = ($urandom_range(7) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
         for (i = 0; i < n; i++) send_byte(rand_digit(), 1'b0);
      end else if (pick < 40) begin
         send_text(kw_words[$urandom_range(6)]);
      end else if (pick < 60) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
         send_ident(n);
      end else if (pick < 85) begin
         send_text(op_texts[$urandom_range(18)]);
      end else if (pick < 97) begin
         send_byte(rand_blank(), 1'b0);
      end else begin
         send_end_mark();
      end
      // keep most tokens apart, the rest run into each other
      if ($urandom_range(2) != 0) send_byte(rand_blank(), 1'b0);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_operators();
      send_text("(){}*+-/%;,");
      send_text("< > = ! <= >= == != <>=!<");
      send_end_mark();
      wait_for_tokens();
   endtask

   task automatic test_keywords();
      send_text("break continue else if int return while iff whilex _Z9 else");
      send_end_mark();
      wait_for_tokens();
   endtask

   task automatic test_numbers();
      send_text("0 2147483647 2147483648 99999999999\t12ab 7");
      send_end_mark();
      wait_for_tokens();
   endtask

   task automatic test_long_idents();
      send_ident(CSL_MAX_IDENT);
      send_byte(CH_SPACE, 1'b0);
      send_ident(CSL_MAX_IDENT + 1);
      send_byte(CH_NEWLINE, 1'b0);
      send_ident(CSL_MAX_IDENT + 5);
      send_end_mark();
      wait_for_tokens();
   endtask

   task automatic test_line_count();
      send_text("a\nb\n\n\t+\n");
      send_end_mark();
      send_text("c");
      send_end_mark();
      send_end_mark();
      wait_for_tokens();
   endtask

   // Hold the response side off while requests keep coming, so the block backs up
   task automatic test_backpressure();
      hold_off = 400;
      send_ident(CSL_MAX_IDENT);
      send_byte(CH_SPACE, 1'b0);
      send_text("if(a<=b){return 0;}");
      send_end_mark();
      wait_for_tokens();
   endtask

   task automatic test_random_stream(input int n_bytes);
      int first;
      first = bytes_sent;
      while (bytes_sent - first < n_bytes) send_random_fragment();
      send_end_mark();
      wait_for_tokens();
   endtask

   // Unknown byte halts the block; later traffic, end marks too, yields nothing
   task automatic test_error_halt();
      logic [7:0] bad;
      int         i;
      send_text("abc");
      case ($urandom_range(3))
         0:       bad = CH_CR;
         1:       bad = CH_NUL;
         2:       bad = CH_ALL_ONE;
         default: begin
            bad = 8'($urandom_range(255));
            while (char_known(bad)) bad = 8'($urandom_range(255));
         end
      endcase
      send_byte(bad, 1'b0);
      for (i = 0; i < 12; i++) send_byte(8'($urandom_range(255)), ($urandom_range(3) == 0));
      wait_for_tokens();
   endtask

   initial begin
      clear_lexer();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      src_idle_pct = 18;
      snk_idle_pct = 48;
      test_operators();
      test_keywords();
      test_numbers();
      test_long_idents();
      test_line_count();
      test_random_stream(26);

      src_idle_pct = 48;
      snk_idle_pct = 18;
      test_backpressure();
      test_random_stream(26);

      src_idle_pct = 0;
      snk_idle_pct = 0;
      test_random_stream(26);
      test_error_halt();

      if (token_errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
